@@ rtl/core/u8dv_pkg.sv @@
package u8dv_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned LEN_W  = 3;
   localparam int unsigned GAT_W  = 2;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'd63;
   localparam logic [CP_W-1:0] MAX_CP         = 21'h10ffff;
   localparam logic [CP_W-1:0] SURR_LO        = 21'h00d800;
   localparam logic [CP_W-1:0] SURR_HI        = 21'h00dfff;
   localparam logic [CP_W-1:0] MIN_CP_LEN2    = 21'h000080;
   localparam logic [CP_W-1:0] MIN_CP_LEN3    = 21'h000800;
   localparam logic [CP_W-1:0] MIN_CP_LEN4    = 21'h010000;

   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

   localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hc2;
   localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hdf;
   localparam logic [BYTE_W-1:0] LEAD3_LO = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hef;
   localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hf0;
   localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hf4;
   localparam logic [BYTE_W-1:0] ASCII_HI = 8'h7f;
   localparam logic [1:0]        CONT_TAG = 2'b10;

   // one word of work for the back end: some replacements, then an optional tail result
   typedef struct packed {
      logic [LEN_W-1:0] nq;
      logic             tail;
      logic [CP_W-1:0]  tail_cp;
      logic             tail_rep;
      logic             tail_end;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ rtl/core/utf8_decoder_validating.sv @@
// utf8_decoder_validating: validating utf-8 decoder, one byte per word in
// input side: drive req_in_byte with push high; the byte is taken at a clock
//   edge where push is high and full is low
// result side: while empty is low the oldest code point sits on the rsp_
//   ports; pop high at a clock edge takes it
// a byte gives zero to four results; rsp_last marks the final result of a
//   byte, rsp_replaced marks a '?' put in for bad input, rsp_end_of_text a nul
// path: a byte's results are written to the command queue and then registered
//   in the output stage before they reach the rsp_ ports
// throughput: one byte per cycle while each byte gives at most one result and
//   pop stays high; the output stage emits one result per cycle while pop is
//   high, so a byte giving several results holds the back end longer and the
//   command queue (QUEUE_DEPTH words) absorbs the difference before full rises
// reset clears the open sequence, the command queue and the output stage
// when the receiver stalls, the output word holds, the queue fills and full
//   is raised; no word is lost or repeated
module utf8_decoder_validating #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   output logic        empty,
   input  logic        pop,
   output logic [20:0] rsp_code_point,
   output logic        rsp_replaced,
   output logic        rsp_end_of_text,
   output logic        rsp_last
);
   import u8dv_pkg::*;

   logic         accept;
   logic         cmd_valid;
   cmd_type      cmd;
   cmd_type      head;
   q_status_type q_status;
   logic         head_pop;
   logic         out_valid;

   assign full   = q_status.full;
   assign accept = push && !q_status.full;
   assign empty  = !out_valid;

   u8dv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   u8dv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_valid),
      .wr_word (cmd),
      .rd_en   (head_pop),
      .rd_word (head),
      .status  (q_status)
   );

   u8dv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (!q_status.empty),
      .head_pop        (head_pop),
      .out_pop         (pop),
      .out_valid       (out_valid),
      .out_code_point  (rsp_code_point),
      .out_replaced    (rsp_replaced),
      .out_end_of_text (rsp_end_of_text),
      .out_last        (rsp_last)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("outputs not cleared after reset");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_rep_value: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_replaced) |-> (rsp_code_point == REPLACEMENT_CP && !rsp_end_of_text))
      else $error("replacement word carries wrong value");

   a_nul_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_end_of_text) |-> (rsp_code_point == '0 && rsp_last))
      else $error("end of text word malformed");

   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> !q_status.empty)
      else $error("queue read while empty");

endmodule

@@ rtl/core/u8dv_front.sv @@
module u8dv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   output logic                 cmd_valid,
   output u8dv_pkg::cmd_type    cmd
);
   import u8dv_pkg::*;

   logic [LEN_W-1:0] exp_ff, exp_in;
   logic [GAT_W-1:0] gat_ff, gat_in;
   logic [CP_W-1:0]  part_ff, part_in;

   logic             is_cont;
   logic [CP_W-1:0]  part_next;
   logic [GAT_W-1:0] gat_next;
   logic [LEN_W-1:0] gat_sum;
   logic             complete;
   logic             seq_ok;
   logic [LEN_W-1:0] broken_nq;

   assign is_cont   = (in_byte[7:6] == CONT_TAG);
   assign part_next = {part_ff[CP_W-7:0], in_byte[5:0]};
   assign gat_next  = gat_ff + 2'd1;
   assign gat_sum   = {1'b0, gat_next} + 3'd1;
   assign complete  = (gat_sum >= exp_ff);
   assign broken_nq = (gat_ff == 2'd3) ? 3'd3 : ({1'b0, gat_ff} + 3'd1);

   always_comb begin
      seq_ok = 1'b1;
      if (exp_ff == LEN_TWO && part_next < MIN_CP_LEN2) seq_ok = 1'b0;
      if (exp_ff == LEN_THREE && part_next < MIN_CP_LEN3) seq_ok = 1'b0;
      if (exp_ff == LEN_FOUR && part_next < MIN_CP_LEN4) seq_ok = 1'b0;
      if (part_next > MAX_CP) seq_ok = 1'b0;
      if (part_next >= SURR_LO && part_next <= SURR_HI) seq_ok = 1'b0;
   end

   always_comb begin
      cmd     = '0;
      exp_in  = exp_ff;
      gat_in  = gat_ff;
      part_in = part_ff;
      if (exp_ff != LEN_NONE && is_cont) begin
         if (complete) begin
            exp_in  = LEN_NONE;
            gat_in  = '0;
            part_in = '0;
            if (seq_ok) begin
               cmd.tail    = 1'b1;
               cmd.tail_cp = part_next;
            end else begin
               cmd.nq = exp_ff;
            end
         end else begin
            gat_in  = gat_next;
            part_in = part_next;
         end
      end else begin
         // open sequence broken: one replacement per buffered byte
         cmd.nq  = (exp_ff != LEN_NONE) ? broken_nq : 3'd0;
         exp_in  = LEN_NONE;
         gat_in  = '0;
         part_in = '0;
         if (in_byte == 8'd0) begin
            cmd.tail     = 1'b1;
            cmd.tail_end = 1'b1;
         end else if (in_byte inside {[8'd1:ASCII_HI]}) begin
            cmd.tail    = 1'b1;
            cmd.tail_cp = {{(CP_W-BYTE_W){1'b0}}, in_byte};
         end else if (in_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
            exp_in  = LEN_TWO;
            part_in = {{(CP_W-5){1'b0}}, in_byte[4:0]};
         end else if (in_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
            exp_in  = LEN_THREE;
            part_in = {{(CP_W-4){1'b0}}, in_byte[3:0]};
         end else if (in_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
            exp_in  = LEN_FOUR;
            part_in = {{(CP_W-3){1'b0}}, in_byte[2:0]};
         end else begin
            cmd.tail     = 1'b1;
            cmd.tail_cp  = REPLACEMENT_CP;
            cmd.tail_rep = 1'b1;
         end
      end
   end

   assign cmd_valid = accept && (cmd.tail || cmd.nq != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= LEN_NONE;
         gat_ff  <= '0;
         part_ff <= '0;
      end else if (accept) begin
         exp_ff  <= exp_in;
         gat_ff  <= gat_in;
         part_ff <= part_in;
      end
   end

endmodule

@@ rtl/core/u8dv_queue.sv @@
module u8dv_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  u8dv_pkg::cmd_type       wr_word,
   input  logic                    rd_en,
   output u8dv_pkg::cmd_type       rd_word,
   output u8dv_pkg::q_status_type  status
);
   import u8dv_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == FULL_CNT);
   assign status.empty = (cnt_ff == '0);
   assign rd_word      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (rd_en) rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (wr_en && !rd_en) cnt_in = cnt_ff + 1'b1;
      else if (rd_en && !wr_en) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_word;
   end

endmodule

@@ rtl/core/u8dv_back.sv @@
module u8dv_back (
   input  logic                    clock,
   input  logic                    reset,
   input  u8dv_pkg::cmd_type       head,
   input  logic                    head_valid,
   output logic                    head_pop,
   input  logic                    out_pop,
   output logic                    out_valid,
   output logic [20:0]             out_code_point,
   output logic                    out_replaced,
   output logic                    out_end_of_text,
   output logic                    out_last
);
   import u8dv_pkg::*;

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [CP_W-1:0]  cp_ff, cp_in;
   logic             rep_ff, rep_in;
   logic             end_ff, end_in;
   logic             last_ff, last_in;
   logic             load;
   logic             in_q;

   assign load = head_valid && (!valid_ff || out_pop);
   assign in_q = (idx_ff < head.nq);

   always_comb begin
      if (in_q) begin
         cp_in   = REPLACEMENT_CP;
         rep_in  = 1'b1;
         end_in  = 1'b0;
         last_in = (idx_ff + 3'd1 == head.nq) && !head.tail;
      end else begin
         cp_in   = head.tail_cp;
         rep_in  = head.tail_rep;
         end_in  = head.tail_end;
         last_in = 1'b1;
      end
      head_pop = load && last_in;
      idx_in   = idx_ff;
      if (load) idx_in = last_in ? '0 : idx_ff + 3'd1;
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (out_pop) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff   <= cp_in;
         rep_ff  <= rep_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_code_point  = cp_ff;
   assign out_replaced    = rep_ff;
   assign out_end_of_text = end_ff;
   assign out_last        = last_ff;

endmodule

@@ test/tb_utf8_decoder_validating.sv @@
module tb_utf8_decoder_validating;
   import u8dv_pkg::*;

   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            rep;
      logic            eot;
      logic            last;
   } cp_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] b;
      logic              typed;
      cp_word_type       w;
   } stim_row_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 64;
   localparam int RANDOM_BYTES   = 85;
   localparam int N_DIRECTED     = 25;

   logic              clock;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic [BYTE_W-1:0] req_in_byte = '0;
   logic              pop = 1'b0;
   logic              full;
   logic              empty;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_replaced;
   logic              rsp_end_of_text;
   logic              rsp_last;

   // decoder state mirrored by the predictor
   logic [LEN_W-1:0]  open_len = LEN_NONE;
   logic [GAT_W-1:0]  gathered_cnt = '0;
   logic [CP_W-1:0]   partial_cp = '0;

   cp_word_type       pending_cps [$];
   logic [BYTE_W-1:0] random_bytes [$];
   int                errors = 0;
   int                bytes_sent = 0;
   int                cps_checked = 0;
   int                reps_seen = 0;
   int                eots_seen = 0;
   int                idle_cycles = 0;
   bit                hold_request = 1'b0;
   bit                hold_done = 1'b0;

   // expected first: typed rows carry their single result
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{8'h00,    1'b1, '{21'd0, 1'b0, 1'b1, 1'b1}},
      '{ASCII_HI, 1'b1, '{21'h7f, 1'b0, 1'b0, 1'b1}},
      '{8'h80,    1'b1, '{REPLACEMENT_CP, 1'b1, 1'b0, 1'b1}},
      '{8'hc0,    1'b1, '{REPLACEMENT_CP, 1'b1, 1'b0, 1'b1}},
      '{8'hf5,    1'b1, '{REPLACEMENT_CP, 1'b1, 1'b0, 1'b1}},
      '{8'hff,    1'b1, '{REPLACEMENT_CP, 1'b1, 1'b0, 1'b1}},
      '{LEAD2_LO, 1'b0, '0},
      '{8'h80,    1'b1, '{MIN_CP_LEN2, 1'b0, 1'b0, 1'b1}},
      '{LEAD4_HI, 1'b0, '0},
      '{8'h8f,    1'b0, '0},
      '{8'hbf,    1'b0, '0},
      '{8'hbf,    1'b1, '{MAX_CP, 1'b0, 1'b0, 1'b1}},
      '{LEAD3_LO, 1'b0, '0},
      '{8'h80,    1'b0, '0},
      '{8'h80,    1'b0, '0},
      '{8'hed,    1'b0, '0},
      '{8'ha0,    1'b0, '0},
      '{8'h80,    1'b0, '0},
      '{LEAD4_HI, 1'b0, '0},
      '{8'h90,    1'b0, '0},
      '{8'h80,    1'b0, '0},
      '{8'h80,    1'b0, '0},
      '{8'he1,    1'b0, '0},
      '{8'h80,    1'b0, '0},
      '{8'h00,    1'b0, '0}
   };

   utf8_decoder_validating u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_in_byte     (req_in_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic cp_word_type make_cp(input logic [CP_W-1:0] cp, input logic rep,
                                           input logic eot);
      make_cp = '{cp, rep, eot, 1'b0};
   endfunction

   function automatic bit seq_valid(input logic [LEN_W-1:0] len, input logic [CP_W-1:0] cp);
      if (len == LEN_TWO && cp < MIN_CP_LEN2) return 1'b0;
      if (len == LEN_THREE && cp < MIN_CP_LEN3) return 1'b0;
      if (len == LEN_FOUR && cp < MIN_CP_LEN4) return 1'b0;
      if (cp > MAX_CP) return 1'b0;
      if (cp >= SURR_LO && cp <= SURR_HI) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void clear_seq();
      open_len = LEN_NONE;
      gathered_cnt = '0;
      partial_cp = '0;
   endfunction

   // code points caused by one byte, state updated on the way
   function automatic int decode_byte(input logic [BYTE_W-1:0] b, output cp_word_type res [4]);
      int n;
      int k;
      n = 0;
      for (k = 0; k < 4; k++) res[k] = '0;
      if (open_len != LEN_NONE) begin
         if (b[7:6] == CONT_TAG) begin
            partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
            gathered_cnt = gathered_cnt + 1'b1;
            if ({1'b0, gathered_cnt} + 3'd1 >= open_len) begin
               if (seq_valid(open_len, partial_cp)) begin
                  res[n] = make_cp(partial_cp, 1'b0, 1'b0);
                  n = n + 1;
               end else begin
                  for (k = 0; k < int'(open_len); k++) begin
                     res[n] = make_cp(REPLACEMENT_CP, 1'b1, 1'b0);
                     n = n + 1;
                  end
               end
               clear_seq();
            end
            if (n > 0) res[n-1].last = 1'b1;
            return n;
         end
         for (k = 0; k < int'(gathered_cnt) + 1 && k < 3; k++) begin
            res[n] = make_cp(REPLACEMENT_CP, 1'b1, 1'b0);
            n = n + 1;
         end
         clear_seq();
      end
      if (b == 8'h00) begin
         res[n] = make_cp('0, 1'b0, 1'b1);
         n = n + 1;
      end else if (b <= ASCII_HI) begin
         res[n] = make_cp({13'd0, b}, 1'b0, 1'b0);
         n = n + 1;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         open_len = LEN_TWO;
         gathered_cnt = '0;
         partial_cp = {16'd0, b[4:0]};
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         open_len = LEN_THREE;
         gathered_cnt = '0;
         partial_cp = {17'd0, b[3:0]};
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         open_len = LEN_FOUR;
         gathered_cnt = '0;
         partial_cp = {18'd0, b[2:0]};
      end else begin
         res[n] = make_cp(REPLACEMENT_CP, 1'b1, 1'b0);
         n = n + 1;
      end
      if (n > 0) res[n-1].last = 1'b1;
      return n;
   endfunction

   // idle length: level is the chance in percent of any gap
   function automatic int idle_len(input int level);
      if ($urandom_range(0, 99) >= level) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 25);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [BYTE_W-1:0] rand_cont();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic add_sequence();
      logic [CP_W-1:0]   cp;
      logic [BYTE_W-1:0] b;
      int                kind;
      int                sub;
      int                need;
      int                k;
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
         random_bytes.push_back(8'($urandom_range(1, 127)));
      end else if (kind < 32) begin
         cp = 21'($urandom_range(32'h80, 32'h7ff));
         random_bytes.push_back({3'b110, cp[10:6]});
         random_bytes.push_back({CONT_TAG, cp[5:0]});
      end else if (kind < 44) begin
         cp = 21'($urandom_range(32'h800, 32'hffff));
         if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h2000;
         random_bytes.push_back({4'b1110, cp[15:12]});
         random_bytes.push_back({CONT_TAG, cp[11:6]});
         random_bytes.push_back({CONT_TAG, cp[5:0]});
      end else if (kind < 56) begin
         cp = 21'($urandom_range(32'h10000, 32'h10ffff));
         random_bytes.push_back({5'b11110, cp[20:18]});
         random_bytes.push_back({CONT_TAG, cp[17:12]});
         random_bytes.push_back({CONT_TAG, cp[11:6]});
         random_bytes.push_back({CONT_TAG, cp[5:0]});
      end else if (kind < 64) begin
         // overlong, surrogate or beyond the last code point
         sub = $urandom_range(0, 3);
         case (sub)
            0: begin
               random_bytes.push_back(LEAD3_LO);
               random_bytes.push_back(8'h80 | 8'($urandom_range(0, 31)));
            end
            1: begin
               random_bytes.push_back(8'hed);
               random_bytes.push_back(8'ha0 | 8'($urandom_range(0, 31)));
            end
            2: begin
               random_bytes.push_back(LEAD4_LO);
               random_bytes.push_back(8'h80 | 8'($urandom_range(0, 15)));
               random_bytes.push_back(rand_cont());
            end
            default: begin
               random_bytes.push_back(LEAD4_HI);
               random_bytes.push_back(8'h90 + 8'($urandom_range(0, 47)));
               random_bytes.push_back(rand_cont());
            end
         endcase
         random_bytes.push_back(rand_cont());
      end else if (kind < 78) begin
         // sequence cut short by a byte that is not a continuation
         b = 8'($urandom_range(LEAD2_LO, LEAD4_HI));
         need = (b >= LEAD4_LO) ? 3 : (b >= LEAD3_LO) ? 2 : 1;
         random_bytes.push_back(b);
         sub = $urandom_range(0, need - 1);
         for (k = 0; k < sub; k++) random_bytes.push_back(rand_cont());
         do b = 8'($urandom_range(0, 255)); while (b[7:6] == CONT_TAG);
         random_bytes.push_back(b);
      end else if (kind < 86) begin
         sub = $urandom_range(0, 12);
         if ($urandom_range(0, 1) == 0) random_bytes.push_back(rand_cont());
         else if (sub < 2) random_bytes.push_back(8'hc0 + 8'(sub));
         else random_bytes.push_back(8'hf5 + 8'(sub - 2));
      end else if (kind < 90) begin
         random_bytes.push_back(8'h00);
      end else begin
         random_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                            input cp_word_type w, input int level);
      cp_word_type res [4];
      int          n;
      int          k;
      int          gap;
      push <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (full);
      n = decode_byte(b, res);
      if (typed) pending_cps.push_back(w);
      else for (k = 0; k < n; k++) pending_cps.push_back(res[k]);
      bytes_sent++;
      gap = (hold_request && !hold_done) ? 0 : idle_len(level);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic note_error(input string what, input cp_word_type want,
                             input cp_word_type got);
      errors++;
      if (errors <= 10)
         $display("mismatch (%s): want cp=%h rep=%b eot=%b last=%b, %s",
                  what, want.cp, want.rep, want.eot, want.last,
                  $sformatf("got cp=%h rep=%b eot=%b last=%b",
                            got.cp, got.rep, got.eot, got.last));
   endtask

   // result side checking
   always @(posedge clock) begin
      cp_word_type got;
      cp_word_type want;
      if (!reset && pop && !empty) begin
         got = '{rsp_code_point, rsp_replaced, rsp_end_of_text, rsp_last};
         if (pending_cps.size() == 0) begin
            note_error("no word expected", '0, got);
         end else begin
            want = pending_cps.pop_front();
            if (want !== got) note_error("field", want, got);
         end
         cps_checked++;
         if (got.rep) reps_seen++;
         if (got.eot) eots_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver
   initial begin
      int level;
      int gap;
      int cyc;
      int k;
      level = 0;
      cyc = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            pop <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            hold_done = 1'b1;
         end
         if (cyc % 32 == 0) level = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 70);
         gap = idle_len(level);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         cyc = cyc + gap + 1;
      end
   end

   // sender and end of run
   initial begin
      int level;
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      level = 30;
      for (k = 0; k < N_DIRECTED; k++)
         send_byte(directed_rows[k].b, directed_rows[k].typed, directed_rows[k].w, level);
      while (random_bytes.size() < RANDOM_BYTES) add_sequence();
      hold_request = 1'b1;
      for (k = 0; k < random_bytes.size(); k++) begin
         if (k % 16 == 0) level = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 70);
         send_byte(random_bytes[k], 1'b0, '0, level);
      end
      push <= 1'b0;
      while (pending_cps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      errors = errors + pending_cps.size();
      $display("fed %0d bytes (%0d directed, %0d random), checked %0d code points",
               bytes_sent, N_DIRECTED, random_bytes.size(), cps_checked);
      $display("%0d replacements, %0d end-of-text words, %0d-cycle receiver hold-off, %0d errors",
               reps_seen, eots_seen, HOLD_CYCLES, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ utf8_decoder_validating.f @@
rtl/core/u8dv_pkg.sv
rtl/core/u8dv_front.sv
rtl/core/u8dv_queue.sv
rtl/core/u8dv_back.sv
rtl/core/utf8_decoder_validating.sv
test/tb_utf8_decoder_validating.sv
